[rtl/unaligned_packed_block_compare_core_macros.svh]
// Assertion macros, sampled on clk and held off while rst_n is low.
`ifndef UNALIGNED_PACKED_BLOCK_COMPARE_CORE_MACROS_SVH
`define UNALIGNED_PACKED_BLOCK_COMPARE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define UPBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upbc assertion failed");
`define UPBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upbc assertion failed");
`else
`define UPBC_ASSERT_SAME(label, ante, cons)
`define UPBC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/upbc_pkg.sv]
`default_nettype none

package upbc_pkg;

    localparam int SYMBOL_BITS = 3;
    localparam int SYMBOLS     = 21;
    localparam int WORD_BITS   = SYMBOL_BITS * SYMBOLS;
    localparam int OFF_BITS    = 5;

    typedef logic [WORD_BITS-1:0]                   word_t;
    typedef logic [OFF_BITS-1:0]                    off_t;
    typedef logic [SYMBOL_BITS-1:0]                 sym_t;
    // index SYMBOLS-1 holds symbol 0 (most significant)
    typedef logic [SYMBOLS-1:0][SYMBOL_BITS-1:0]    block_t;

    localparam off_t OFFSET_MAX = off_t'(SYMBOLS - 1);

    typedef struct packed {
        logic neq;
        logic lt;
    } lane_res_t;

    typedef lane_res_t [SYMBOLS-1:0] lane_vec_t;

    typedef struct packed {
        logic found;
        logic a_less;
    } merge_res_t;

endpackage

`default_nettype wire

[rtl/upbc_in_if.sv]
`default_nettype none

interface upbc_in_if;

    logic              valid;
    logic              ready;
    logic              start_req;
    upbc_pkg::off_t    offset_a;
    upbc_pkg::off_t    offset_b;
    upbc_pkg::word_t   word_a;
    upbc_pkg::word_t   word_b;

    modport source (
        output valid,
        output start_req,
        output offset_a,
        output offset_b,
        output word_a,
        output word_b,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_req,
        input  offset_a,
        input  offset_b,
        input  word_a,
        input  word_b,
        output ready
    );

endinterface

`default_nettype wire

[rtl/upbc_out_if.sv]
`default_nettype none

interface upbc_out_if;

    logic valid;
    logic ready;
    logic a_less;

    modport source (
        output valid,
        output a_less,
        input  ready
    );

    modport sink (
        input  valid,
        input  a_less,
        output ready
    );

endinterface

`default_nettype wire

[rtl/unaligned_packed_block_compare_core.sv]
// A deciding item's result is registered in the output register when it is accepted,
// or in the skid register while an earlier result still waits at the output.
// 1 item per cycle while in_ch.ready; alignment, 21 lanes and merge are combinational.
// in_ch.ready drops only while both the output register and skid register hold results.
// Reset (rst_n low, async) clears the comparing flag, offsets and both output stages;
// the block is idle until the next start item.
`default_nettype none

`include "unaligned_packed_block_compare_core_macros.svh"

module unaligned_packed_block_compare_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    upbc_in_if.sink     in_ch,
    upbc_out_if.source  out_ch
);

    upbc_pkg::word_t      prev_a_reg, prev_a_next;
    upbc_pkg::word_t      prev_b_reg, prev_b_next;
    upbc_pkg::off_t       shift_a_reg, shift_a_next;
    upbc_pkg::off_t       shift_b_reg, shift_b_next;
    logic                 comparing_reg, comparing_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 skid_data_reg, skid_data_next;

    upbc_pkg::block_t     block_a;
    upbc_pkg::block_t     block_b;
    upbc_pkg::lane_vec_t  lanes;
    upbc_pkg::merge_res_t merged;

    logic                 accept;
    logic                 push;
    logic                 pop;

    upbc_align u_align_a (
        .prev_word (prev_a_reg),
        .cur_word  (in_ch.word_a),
        .offset    (shift_a_reg),
        .block     (block_a)
    );

    upbc_align u_align_b (
        .prev_word (prev_b_reg),
        .cur_word  (in_ch.word_b),
        .offset    (shift_b_reg),
        .block     (block_b)
    );

    for (genvar i = 0; i < upbc_pkg::SYMBOLS; i++)
    begin : g_lane
        upbc_lane u_lane (
            .sym_a (block_a[i]),
            .sym_b (block_b[i]),
            .res   (lanes[i])
        );
    end

    upbc_merge u_merge (
        .lanes (lanes),
        .res   (merged)
    );

    assign in_ch.ready   = !skid_valid_reg;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.a_less = out_data_reg;

    assign accept = in_ch.valid && in_ch.ready;
    assign push   = accept && !in_ch.start_req && comparing_reg && merged.found;
    assign pop    = out_valid_reg && out_ch.ready;

    always_comb
    begin
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        shift_a_next   = shift_a_reg;
        shift_b_next   = shift_b_reg;
        comparing_next = comparing_reg;

        if (accept)
        begin
            if (in_ch.start_req)
            begin
                shift_a_next   = (in_ch.offset_a > upbc_pkg::OFFSET_MAX) ?
                                 upbc_pkg::OFFSET_MAX : in_ch.offset_a;
                shift_b_next   = (in_ch.offset_b > upbc_pkg::OFFSET_MAX) ?
                                 upbc_pkg::OFFSET_MAX : in_ch.offset_b;
                prev_a_next    = in_ch.word_a;
                prev_b_next    = in_ch.word_b;
                comparing_next = 1'b1;
            end
            else if (comparing_reg)
            begin
                prev_a_next = in_ch.word_a;
                prev_b_next = in_ch.word_b;
                if (merged.found)
                begin
                    comparing_next = 1'b0;
                end
            end
        end
    end

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = merged.a_less;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = merged.a_less;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_a_reg    <= '0;
            shift_b_reg    <= '0;
            comparing_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            shift_a_reg    <= shift_a_next;
            shift_b_reg    <= shift_b_next;
            comparing_reg  <= comparing_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_a_reg    <= prev_a_next;
        prev_b_reg    <= prev_b_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `UPBC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `UPBC_ASSERT_NEXT(a_push_shows, push, out_valid_reg)
    `UPBC_ASSERT_NEXT(a_push_ends_compare, push, !comparing_reg)
    `UPBC_ASSERT_NEXT(a_start_arms, accept && in_ch.start_req,
        comparing_reg && shift_a_reg <= upbc_pkg::OFFSET_MAX &&
        shift_b_reg <= upbc_pkg::OFFSET_MAX)
    `UPBC_ASSERT_NEXT(a_idle_holds, !comparing_reg && !(accept && in_ch.start_req),
        !comparing_reg)

endmodule

`default_nettype wire

[rtl/upbc_align.sv]
`default_nettype none

// Funnel shift: 21 symbols starting at symbol 'offset' of prev_word, running on into cur_word.
module upbc_align (
    input  upbc_pkg::word_t  prev_word,
    input  upbc_pkg::word_t  cur_word,
    input  upbc_pkg::off_t   offset,
    output upbc_pkg::block_t block
);

    localparam int JOIN_BITS  = 2 * upbc_pkg::WORD_BITS;
    localparam int SHIFT_BITS = $clog2(upbc_pkg::WORD_BITS);

    logic [SHIFT_BITS-1:0] left;
    logic [JOIN_BITS-1:0]  joined;

    always_comb
    begin
        left   = SHIFT_BITS'(offset) * SHIFT_BITS'(upbc_pkg::SYMBOL_BITS);
        joined = {prev_word, cur_word} << left;
        block  = joined[JOIN_BITS-1 -: upbc_pkg::WORD_BITS];
    end

endmodule

`default_nettype wire

[rtl/upbc_lane.sv]
`default_nettype none

module upbc_lane (
    input  upbc_pkg::sym_t      sym_a,
    input  upbc_pkg::sym_t      sym_b,
    output upbc_pkg::lane_res_t res
);

    always_comb
    begin
        res.neq = (sym_a != sym_b);
        res.lt  = (sym_a < sym_b);
    end

endmodule

`default_nettype wire

[rtl/upbc_merge.sv]
`default_nettype none

// First differing symbol wins; lane SYMBOLS-1 carries symbol 0.
module upbc_merge (
    input  upbc_pkg::lane_vec_t  lanes,
    output upbc_pkg::merge_res_t res
);

    always_comb
    begin
        res = '0;
        for (int k = 0; k < upbc_pkg::SYMBOLS; k++)
        begin
            if (lanes[k].neq)
            begin
                res.found  = 1'b1;
                res.a_less = lanes[k].lt;
            end
        end
    end

endmodule

`default_nettype wire
